### rtl/core/zvt_pkg.sv
package zvt_pkg;

    localparam int NUM_BINS   = 256;
    localparam int MAX_TRACKS = 512;
    localparam int TOP_K      = 10;

    localparam int BIN_BITS  = $clog2(NUM_BINS);
    localparam int TRK_BITS  = $clog2(MAX_TRACKS);
    localparam int TOPK_BITS = $clog2(TOP_K + 1);
    localparam int TOPI_BITS = (TOP_K > 1) ? $clog2(TOP_K) : 1;

    localparam int PT_W    = 20;
    localparam int Z0_W    = 15;
    localparam int D0_W    = 16;
    localparam int ETA_W   = 14;
    localparam int PHI_W   = 16;
    localparam int TRK_W   = PT_W + Z0_W + D0_W + ETA_W + PHI_W;
    localparam int SUM_W   = 29;
    localparam int ETAL_W  = 13;
    localparam int RCNT_W  = 4;
    localparam int RANK_W  = 4;
    localparam int PEAK_W  = 9;
    localparam int IN_TD_W  = 88;
    localparam int OUT_TD_W = 96;
    localparam int CFG_A_W  = 1;

    localparam logic [CFG_A_W-1:0] REG_ETA_LIMIT    = 1'b0;
    localparam logic [CFG_A_W-1:0] REG_REPORT_COUNT = 1'b1;

    localparam logic [ETAL_W-1:0] ETA_LIMIT_RST    = 13'd3072;
    localparam logic [RCNT_W-1:0] REPORT_COUNT_RST = 4'd10;

    typedef struct packed {
        logic [PHI_W-1:0] phi;
        logic [ETA_W-1:0] eta;
        logic [D0_W-1:0]  d0;
        logic [Z0_W-1:0]  z0;
        logic [PT_W-1:0]  pt;
    } track_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HADD,
        ST_SCAN,
        ST_SEL,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic clr_step;
        logic hist_add;
        logic scan_init;
        logic scan_step;
        logic sel_init;
        logic sel_step;
        logic emit_init;
        logic emit_rd;
        logic emit_ld;
        logic emit_next;
        logic event_done;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic scan_done;
        logic sel_done;
        logic out_fire;
        logic out_last;
    } stat_t;

    function automatic logic z0_in_range(input logic [Z0_W-1:0] z);
        return z[Z0_W-1] == z[Z0_W-2];
    endfunction

    function automatic logic [BIN_BITS-1:0] z0_bin(input logic [Z0_W-1:0] z);
        logic [Z0_W-2:0] off;
        off = {~z[Z0_W-2], z[Z0_W-3:0]};
        return off[Z0_W-2 -: BIN_BITS];
    endfunction

endpackage

### rtl/core/zvt_ctrl.sv
module zvt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    input  logic          s_tlast,
    input  zvt_pkg::stat_t stat,
    output zvt_pkg::cmd_t  cmd
);
    import zvt_pkg::*;

    state_t state_reg, state_next;
    logic   last_reg, last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        case (state_reg)
            ST_CLEAR:     if (stat.clr_done) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_HADD;
                    last_next  = s_tlast;
                end
            end
            ST_HADD:      state_next = last_reg ? ST_SCAN : ST_IDLE;
            ST_SCAN:      if (stat.scan_done) state_next = ST_SEL;
            ST_SEL:       if (stat.sel_done) state_next = ST_EMIT_RD;
            ST_EMIT_RD:   state_next = ST_EMIT_LD;
            ST_EMIT_LD:   state_next = ST_EMIT_WAIT;
            ST_EMIT_WAIT:
            begin
                if (stat.out_fire)
                    state_next = stat.out_last ? ST_IDLE : ST_EMIT_RD;
            end
            default:      state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_CLEAR: cmd.clr_step = 1'b1;
            ST_IDLE:  cmd.accept = 1'b1;
            ST_HADD:
            begin
                cmd.hist_add  = 1'b1;
                cmd.scan_init = last_reg;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                cmd.sel_init  = stat.scan_done;
            end
            ST_SEL:
            begin
                cmd.sel_step  = 1'b1;
                cmd.emit_init = stat.sel_done;
            end
            ST_EMIT_RD: cmd.emit_rd = 1'b1;
            ST_EMIT_LD: cmd.emit_ld = 1'b1;
            ST_EMIT_WAIT:
            begin
                cmd.event_done = stat.out_fire & stat.out_last;
                cmd.emit_next  = stat.out_fire & ~stat.out_last;
            end
            default: cmd = '0;
        endcase
    end

endmodule

### rtl/core/zvt_dp.sv
module zvt_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  zvt_pkg::cmd_t                        cmd,
    output zvt_pkg::stat_t                       stat,
    input  logic                                s_tvalid,
    input  logic [zvt_pkg::IN_TD_W-1:0]          s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [zvt_pkg::OUT_TD_W-1:0]         m_tdata,
    output logic [1:0]                          m_tuser,
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [zvt_pkg::CFG_A_W-1:0]          cfg_addr,
    input  logic [zvt_pkg::ETAL_W-1:0]           cfg_wdata
);
    import zvt_pkg::*;

    logic [SUM_W-1:0]    hmem [NUM_BINS];
    logic [TRK_W-1:0]    smem [MAX_TRACKS];

    track_t              in_trk;
    logic                full;
    logic                acc;

    logic [SUM_W-1:0]    h_rdata_reg;
    logic [BIN_BITS-1:0] h_raddr, h_waddr;
    logic [SUM_W-1:0]    h_wdata;
    logic                h_we;
    logic [SUM_W:0]      h_sum;

    track_t              st_rd_reg;
    logic [TRK_BITS-1:0] s_raddr;

    logic [ETAL_W-1:0]   eta_limit_reg;
    logic [RCNT_W-1:0]   report_count_reg;
    logic [TOPK_BITS-1:0] k_lim;

    logic [TRK_BITS:0]   track_count_reg;
    logic                ovf_reg;

    logic [BIN_BITS-1:0] hadd_bin_reg;
    logic [PT_W-1:0]     hadd_pt_reg;
    logic                hadd_en_reg;

    logic [BIN_BITS:0]   bcnt_reg;
    logic [SUM_W-1:0]    best_sum_reg;
    logic [BIN_BITS-1:0] best_reg;

    logic [TRK_BITS:0]   tcnt_reg;
    logic                sel_vld_reg;
    logic [TRK_BITS-1:0] sel_idx_reg;

    logic [TRK_BITS-1:0] top_idx_reg [TOP_K];
    logic [PT_W-1:0]     top_pt_reg  [TOP_K];
    logic [TOPK_BITS-1:0] fill_reg;
    logic [TOPK_BITS-1:0] rcnt_reg;

    logic                out_vld_reg;
    logic                out_last_reg;
    logic [OUT_TD_W-1:0] out_data_reg;
    logic [1:0]          out_user_reg;

    logic [ETA_W-1:0]    abs_eta;
    logic                sel_match;
    logic [TOPK_BITS-1:0] ins_pos;
    logic [TOPK_BITS-1:0] eff_last;

    assign in_trk = track_t'(s_tdata[TRK_W-1:0]);
    assign full   = track_count_reg == (TRK_BITS+1)'(MAX_TRACKS);
    assign acc    = cmd.accept & s_tvalid;

    always_comb
    begin
        if (report_count_reg == '0)
            k_lim = TOPK_BITS'(1);
        else if (32'(report_count_reg) > TOP_K)
            k_lim = TOPK_BITS'(TOP_K);
        else
            k_lim = TOPK_BITS'(report_count_reg);
    end

    // histogram port control
    assign h_raddr = cmd.scan_step ? bcnt_reg[BIN_BITS-1:0] : z0_bin(in_trk.z0);
    assign h_sum   = {1'b0, h_rdata_reg} + (SUM_W+1)'(hadd_pt_reg);

    always_comb
    begin
        h_we    = 1'b0;
        h_waddr = bcnt_reg[BIN_BITS-1:0];
        h_wdata = '0;
        if (cmd.clr_step)
            h_we = 1'b1;
        else if (cmd.hist_add)
        begin
            h_we    = hadd_en_reg;
            h_waddr = hadd_bin_reg;
            h_wdata = h_sum[SUM_W] ? {SUM_W{1'b1}} : h_sum[SUM_W-1:0];
        end
        else if (cmd.scan_step)
            h_we = bcnt_reg != (BIN_BITS+1)'(NUM_BINS);
    end

    always_ff @(posedge clk)
    begin
        if (h_we)
            hmem[h_waddr] <= h_wdata;
        h_rdata_reg <= hmem[h_raddr];
    end

    assign s_raddr = cmd.emit_rd ? top_idx_reg[rcnt_reg[TOPI_BITS-1:0]]
                                 : tcnt_reg[TRK_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (acc && !full)
            smem[track_count_reg[TRK_BITS-1:0]] <= s_tdata[TRK_W-1:0];
        st_rd_reg <= track_t'(smem[s_raddr]);
    end

    // selection test on the word read back
    assign abs_eta   = st_rd_reg.eta[ETA_W-1] ? (~st_rd_reg.eta + 1'b1) : st_rd_reg.eta;
    assign sel_match = sel_vld_reg && z0_in_range(st_rd_reg.z0)
                       && (z0_bin(st_rd_reg.z0) == best_reg)
                       && ({1'b0, eta_limit_reg} >= abs_eta);

    always_comb
    begin
        ins_pos = '0;
        for (int j = 0; j < TOP_K; j++)
            if ((TOPK_BITS'(j) < fill_reg) && (top_pt_reg[j] >= st_rd_reg.pt))
                ins_pos = ins_pos + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (sel_match && ins_pos < k_lim)
        begin
            for (int j = 0; j < TOP_K; j++)
            begin
                if (TOPK_BITS'(j) == ins_pos)
                begin
                    top_idx_reg[j] <= sel_idx_reg;
                    top_pt_reg[j]  <= st_rd_reg.pt;
                end
                else if (j > 0 && TOPK_BITS'(j) > ins_pos && TOPK_BITS'(j) < k_lim)
                begin
                    top_idx_reg[j] <= top_idx_reg[(j > 0) ? j - 1 : 0];
                    top_pt_reg[j]  <= top_pt_reg[(j > 0) ? j - 1 : 0];
                end
            end
        end
    end

    assign eff_last = fill_reg - 1'b1;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            hadd_bin_reg <= z0_bin(in_trk.z0);
            hadd_pt_reg  <= in_trk.pt;
        end
        if (cmd.sel_step)
            sel_idx_reg <= tcnt_reg[TRK_BITS-1:0];
        if (cmd.emit_ld)
        begin
            if (fill_reg == '0)
            begin
                out_data_reg <= {(OUT_TD_W-(RANK_W+TRK_W))'({1'b0, best_reg} + 1'b1),
                                 {(RANK_W+TRK_W){1'b0}}};
                out_user_reg <= {ovf_reg, 1'b0};
            end
            else
            begin
                out_data_reg <= {(OUT_TD_W-(RANK_W+TRK_W))'({1'b0, best_reg} + 1'b1),
                                 st_rd_reg, RANK_W'(rcnt_reg)};
                out_user_reg <= {ovf_reg, 1'b1};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eta_limit_reg    <= ETA_LIMIT_RST;
            report_count_reg <= REPORT_COUNT_RST;
            track_count_reg  <= '0;
            ovf_reg          <= 1'b0;
            hadd_en_reg      <= 1'b0;
            bcnt_reg         <= '0;
            best_sum_reg     <= '0;
            best_reg         <= '0;
            tcnt_reg         <= '0;
            sel_vld_reg      <= 1'b0;
            fill_reg         <= '0;
            rcnt_reg         <= '0;
            out_vld_reg      <= 1'b0;
            out_last_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_ETA_LIMIT:    eta_limit_reg    <= cfg_wdata;
                    REG_REPORT_COUNT: report_count_reg <= cfg_wdata[RCNT_W-1:0];
                    default: ;
                endcase
            end

            if (acc)
            begin
                hadd_en_reg <= ~full & z0_in_range(in_trk.z0);
                if (full)
                    ovf_reg <= 1'b1;
                else
                    track_count_reg <= track_count_reg + 1'b1;
            end

            if (cmd.clr_step)
                bcnt_reg <= bcnt_reg + 1'b1;

            if (cmd.scan_init)
            begin
                bcnt_reg     <= '0;
                best_sum_reg <= '0;
                best_reg     <= '0;
            end
            else if (cmd.scan_step)
            begin
                if (bcnt_reg != (BIN_BITS+1)'(NUM_BINS))
                    bcnt_reg <= bcnt_reg + 1'b1;
                if (bcnt_reg != '0 && h_rdata_reg > best_sum_reg)
                begin
                    best_sum_reg <= h_rdata_reg;
                    best_reg     <= BIN_BITS'(bcnt_reg - 1'b1);
                end
            end

            if (cmd.sel_init)
            begin
                tcnt_reg    <= '0;
                sel_vld_reg <= 1'b0;
                fill_reg    <= '0;
            end
            else if (cmd.sel_step)
            begin
                if (tcnt_reg < track_count_reg)
                begin
                    tcnt_reg    <= tcnt_reg + 1'b1;
                    sel_vld_reg <= 1'b1;
                end
                else
                    sel_vld_reg <= 1'b0;
                if (sel_match && ins_pos < k_lim && fill_reg < k_lim)
                    fill_reg <= fill_reg + 1'b1;
            end

            if (cmd.emit_init)
                rcnt_reg <= '0;
            else if (cmd.emit_next)
                rcnt_reg <= rcnt_reg + 1'b1;

            if (cmd.emit_ld)
            begin
                out_vld_reg  <= 1'b1;
                out_last_reg <= (fill_reg == '0) || (rcnt_reg == eff_last);
            end
            else if (out_vld_reg && m_tready)
                out_vld_reg <= 1'b0;

            if (cmd.event_done)
            begin
                track_count_reg <= '0;
                ovf_reg         <= 1'b0;
            end
        end
    end

    assign stat.clr_done  = bcnt_reg == (BIN_BITS+1)'(NUM_BINS - 1);
    assign stat.scan_done = bcnt_reg == (BIN_BITS+1)'(NUM_BINS);
    assign stat.sel_done  = (tcnt_reg == track_count_reg) && !sel_vld_reg;
    assign stat.out_fire  = out_vld_reg & m_tready;
    assign stat.out_last  = out_last_reg;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

### rtl/core/z0_histogram_vertex_top_tracks.sv
// Track phase: per track a store write and bin read, then a bin update.
// End of event: a peak scan that also clears the bins, then selection
// through the track memory read port, then for each result a read, a load
// and a wait for the output handshake, which lasts as long as the output stalls.
// After reset the block clears the histogram before taking the first
// word; the track memory is not cleared.
module z0_histogram_vertex_top_tracks (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // pt, z0, d0, eta, phi
    input  logic [zvt_pkg::IN_TD_W-1:0]        s_tdata,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // rank, out_pt, out_z0, out_d0, out_eta, out_phi, peak_bin
    output logic [zvt_pkg::OUT_TD_W-1:0]       m_tdata,
    // found, store_overflow
    output logic [1:0]                        m_tuser,
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [zvt_pkg::CFG_A_W-1:0]        cfg_addr,
    input  logic [zvt_pkg::ETAL_W-1:0]         cfg_wdata
);
    import zvt_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign s_tready = cmd.accept;

    zvt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .stat     (stat),
        .cmd      (cmd)
    );

    zvt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import zvt_pkg::*;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [PT_W-1:0]   pt;
        logic [Z0_W-1:0]   z0;
        logic [D0_W-1:0]   d0;
        logic [ETA_W-1:0]  eta;
        logic [PHI_W-1:0]  phi;
        logic [PEAK_W-1:0] peak;
        logic              found;
        logic              ovf;
        logic              last;
    } report_t;

    class vertex_report_model;
        logic [SUM_W-1:0]  bin_sum [NUM_BINS];
        track_t            stored [MAX_TRACKS];
        int                n_stored;
        bit                overflow;
        logic [ETAL_W-1:0] eta_limit;
        logic [RCNT_W-1:0] report_count;
        report_t           pending_reports [$];
        int                mismatches;

        function new();
            foreach (bin_sum[b]) bin_sum[b] = '0;
            n_stored = 0;
            overflow = 0;
            eta_limit = ETA_LIMIT_RST;
            report_count = REPORT_COUNT_RST;
            mismatches = 0;
        endfunction

        function int bin_index(logic [Z0_W-1:0] z0);
            int z;
            z = int'($signed(z0));
            if (z < -8192 || z >= 8192)
                return -1;
            return (z + 8192) >> 6;
        endfunction

        function void take_track(track_t t, bit last);
            int bn;
            longint s;
            int best;
            int k;
            int e;
            int sel [$];
            bit used [$];
            int pick;
            report_t r;
            if (n_stored < MAX_TRACKS) begin
                stored[n_stored] = t;
                n_stored++;
                bn = bin_index(t.z0);
                if (bn >= 0) begin
                    s = longint'(bin_sum[bn]) + longint'(t.pt);
                    bin_sum[bn] = (s > 64'h1FFFFFFF) ? 29'h1FFFFFFF : s[SUM_W-1:0];
                end
            end else
                overflow = 1;
            if (!last)
                return;
            best = 0;
            for (int b = 1; b < NUM_BINS; b++)
                if (bin_sum[b] > bin_sum[best])
                    best = b;
            k = report_count;
            if (k < 1) k = 1;
            if (k > TOP_K) k = TOP_K;
            for (int i = 0; i < n_stored; i++) begin
                e = int'($signed(stored[i].eta));
                if (e < 0) e = -e;
                if (bin_index(stored[i].z0) == best && e <= int'(eta_limit)) begin
                    sel.push_back(i);
                    used.push_back(0);
                end
            end
            if (sel.size() == 0) begin
                r = '0;
                r.peak = PEAK_W'(best + 1);
                r.ovf = overflow;
                r.last = 1;
                pending_reports.push_back(r);
            end else begin
                if (k > sel.size()) k = sel.size();
                for (int n = 0; n < k; n++) begin
                    pick = -1;
                    foreach (sel[j])
                        if (!used[j] && (pick < 0 || stored[sel[j]].pt > stored[sel[pick]].pt))
                            pick = j;
                    used[pick] = 1;
                    r.rank = RANK_W'(n);
                    r.pt = stored[sel[pick]].pt;
                    r.z0 = stored[sel[pick]].z0;
                    r.d0 = stored[sel[pick]].d0;
                    r.eta = stored[sel[pick]].eta;
                    r.phi = stored[sel[pick]].phi;
                    r.peak = PEAK_W'(best + 1);
                    r.found = 1;
                    r.ovf = overflow;
                    r.last = (n == k - 1);
                    pending_reports.push_back(r);
                end
            end
            foreach (bin_sum[b]) bin_sum[b] = '0;
            n_stored = 0;
            overflow = 0;
        endfunction

        function void cmp_field(string name, longint unsigned e, longint unsigned g);
            if (e != g) begin
                $error("%s: expected %0h, got %0h", name, e, g);
                mismatches++;
            end
        endfunction

        function void check_report(report_t g);
            report_t e;
            if (pending_reports.size() == 0) begin
                $error("unexpected output word %h", g);
                mismatches++;
                return;
            end
            e = pending_reports.pop_front();
            cmp_field("rank", e.rank, g.rank);
            cmp_field("out_pt", e.pt, g.pt);
            cmp_field("out_z0", e.z0, g.z0);
            cmp_field("out_d0", e.d0, g.d0);
            cmp_field("out_eta", e.eta, g.eta);
            cmp_field("out_phi", e.phi, g.phi);
            cmp_field("peak_bin", e.peak, g.peak);
            cmp_field("found", e.found, g.found);
            cmp_field("store_overflow", e.ovf, g.ovf);
            cmp_field("last_result", e.last, g.last);
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_TD_W-1:0]  s_tdata;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_TD_W-1:0] m_tdata;
    logic [1:0]          m_tuser;
    logic                m_tlast;
    logic                cfg_we;
    logic [CFG_A_W-1:0]  cfg_addr;
    logic [ETAL_W-1:0]   cfg_wdata;

    vertex_report_model model;
    bit calm;
    int stall_left;

    z0_histogram_vertex_top_tracks dut (.*);

    initial clk = 0;
    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    initial
    begin
        #30ms;
        $display("TB_ERROR");
        $finish;
    end

    // output side: random stall bursts, checking on each accepted word
    always @(posedge clk or negedge rst_n)
    begin
        report_t g;
        if (!rst_n)
        begin
            m_tready <= 0;
            stall_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                g.rank  = m_tdata[3:0];
                g.pt    = m_tdata[23:4];
                g.z0    = m_tdata[38:24];
                g.d0    = m_tdata[54:39];
                g.eta   = m_tdata[68:55];
                g.phi   = m_tdata[84:69];
                g.peak  = m_tdata[93:85];
                g.found = m_tuser[0];
                g.ovf   = m_tuser[1];
                g.last  = m_tlast;
                model.check_report(g);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 0;
            end
            else if (!calm && $urandom_range(4) == 0)
            begin
                stall_left = $urandom_range(0, 16);
                m_tready <= 0;
            end
            else
                m_tready <= 1;
        end
    end

    task automatic send(input logic [19:0] pt, input int z0, input int d0,
                        input int eta, input int phi, input bit last);
        track_t t;
        t.pt = pt;
        t.z0 = z0[Z0_W-1:0];
        t.d0 = d0[D0_W-1:0];
        t.eta = eta[ETA_W-1:0];
        t.phi = phi[PHI_W-1:0];
        if (!calm && $urandom_range(5) == 0)
        begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tdata <= {{(IN_TD_W - TRK_W){1'b0}}, t};
        s_tlast <= last;
        s_tvalid <= 1;
        do @(posedge clk); while (!s_tready);
        model.take_track(t, last);
    endtask

    task automatic drain;
        s_tvalid <= 0;
        while (model.pending_reports.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_A_W-1:0] a, input int v);
        cfg_we <= 1;
        cfg_addr <= a;
        cfg_wdata <= v[ETAL_W-1:0];
        @(posedge clk);
        cfg_we <= 0;
        if (a == REG_ETA_LIMIT)
            model.eta_limit = v[ETAL_W-1:0];
        else
            model.report_count = v[RCNT_W-1:0];
    endtask

    task automatic random_event(input int n);
        int zc;
        int z;
        int e;
        logic [19:0] p;
        zc = $urandom_range(0, 16383) - 8192;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(9))
                0: z = $urandom_range(0, 32767) - 16384;
                default: z = zc + $urandom_range(0, 160) - 80;
            endcase
            case ($urandom_range(4))
                0: p = 20'($urandom_range(0, 3) * 1000);
                1: p = 20'hFFFFF;
                default: p = 20'($urandom);
            endcase
            e = ($urandom_range(2) == 0) ? $urandom_range(0, 16383) - 8192
                                         : $urandom_range(0, 8000) - 4000;
            send(p, z, $urandom, e, $urandom, i == n - 1);
        end
    endtask

    task automatic random_phase(input int items);
        int sent;
        int n;
        sent = 0;
        while (sent < items)
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            random_event(n);
            sent += n;
        end
        drain();
    endtask

    initial
    begin
        model = new();
        calm = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tlast = 0;
        cfg_we = 0;
        cfg_addr = '0;
        cfg_wdata = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // extremes of every field, out-of-range z0 on both edges, pT ties
        send(20'h0, -16384, -32768, -8192, -32768, 0);
        send(20'hFFFFF, 16383, 32767, 8191, 32767, 0);
        send(20'h100, -8193, 0, 0, 0, 0);
        send(20'h100, 8192, 0, 0, 0, 0);
        send(20'h200, -8192, 1, 3072, 2, 0);
        send(20'h10, 8191, 3, -3072, 4, 0);
        send(20'h500, 0, 5, 3072, 6, 0);
        send(20'h500, 10, 7, -3072, 8, 0);
        send(20'h500, 20, 9, 3073, 10, 0);
        send(20'hFFFFF, 30, 11, -3073, 12, 0);
        send(20'h0, 40, 13, 0, 14, 0);
        send(20'h700, 50, -1, -1, -1, 1);
        drain();
        // empty histogram: nothing selected
        send(20'h123, 16000, 1, 0, 1, 1);
        // all-zero histogram with one in-range track at bin 0
        send(20'h0, -8192, 2, 0, 3, 1);
        // peak found but every track rejected by eta
        send(20'h50, 100, 4, 8000, 5, 0);
        send(20'h60, 110, 6, -8000, 7, 1);
        drain();

        // store full: pT sum ends just below saturation, extra tracks dropped, last one dropped too
        for (int i = 0; i < MAX_TRACKS + 3; i++)
            send(20'hFFFFF, 1000, i, (i % 4 == 0) ? 0 : 5000, i, i == MAX_TRACKS + 2);
        drain();

        write_reg(REG_ETA_LIMIT, 0);
        write_reg(REG_REPORT_COUNT, 1);
        random_phase(15);
        write_reg(REG_ETA_LIMIT, 8191);
        write_reg(REG_REPORT_COUNT, 10);
        random_phase(20);
        write_reg(REG_REPORT_COUNT, 0);
        random_phase(15);
        write_reg(REG_REPORT_COUNT, 15);
        write_reg(REG_ETA_LIMIT, 2000);
        random_phase(15);
        for (int ph = 0; ph < 3; ph++)
        begin
            write_reg(REG_ETA_LIMIT, $urandom_range(0, 8191));
            write_reg(REG_REPORT_COUNT, $urandom_range(1, 10));
            random_phase(15);
        end
        calm = 1;
        write_reg(REG_ETA_LIMIT, 3072);
        random_phase(20);

        repeat (300) @(posedge clk);
        if (model.mismatches == 0 && model.pending_reports.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
